// ===== design/klvs_pkg.sv =====
// ----------------------------------------------------------------------------
// klvs_pkg
// Shared widths and the control word that travels down the cell chain.
// ----------------------------------------------------------------------------
package klvs_pkg;

  localparam int KEY_W    = 32;
  localparam int IN_VAL_W = 32;
  localparam int SUM_W    = 40;
  localparam int MAX_VW   = 32;

  typedef struct packed {
    logic valid;
    logic found;
    logic placed;
  } klvs_ctl_t;

endpackage

// ===== design/klvs_cell.sv =====
// ----------------------------------------------------------------------------
// klvs_cell
// One table entry plus one stage of the request pipeline that passes through it.
// ----------------------------------------------------------------------------
module klvs_cell #(
  parameter int VW = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  klvs_pkg::klvs_ctl_t        ctl_i,
  input  logic [klvs_pkg::KEY_W-1:0] key_i,
  input  logic [VW-1:0]              val_i,
  input  logic [VW:0]                delta_i,
  output klvs_pkg::klvs_ctl_t        ctl_o,
  output logic [klvs_pkg::KEY_W-1:0] key_o,
  output logic [VW-1:0]              val_o,
  output logic [VW:0]                delta_o
);

  logic                       vld_r;
  logic [klvs_pkg::KEY_W-1:0] key_r;
  logic [VW-1:0]              val_r;
  klvs_pkg::klvs_ctl_t        ctl_r;
  klvs_pkg::klvs_ctl_t        ctl_nxt;
  logic [klvs_pkg::KEY_W-1:0] tkey_r;
  logic [VW-1:0]              tval_r;
  logic [VW:0]                delta_r;
  logic [VW:0]                delta_nxt;
  logic                       open;
  logic                       hit;
  logic                       place;

  assign open  = ctl_i.valid && !ctl_i.found && !ctl_i.placed;
  assign hit   = open && vld_r && (key_r == key_i);
  assign place = open && !vld_r;

  always_comb begin
    ctl_nxt        = ctl_i;
    ctl_nxt.found  = ctl_i.found || hit;
    ctl_nxt.placed = ctl_i.placed || place;
    if (hit) begin
      delta_nxt = {val_i[VW-1], val_i} - {val_r[VW-1], val_r};
    end else if (place) begin
      delta_nxt = {val_i[VW-1], val_i};
    end else begin
      delta_nxt = delta_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
      if (place) begin
        vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tkey_r  <= key_i;
      tval_r  <= val_i;
      delta_r <= delta_nxt;
      if (place) begin
        key_r <= key_i;
      end
      if (hit || place) begin
        val_r <= val_i;
      end
    end
  end

  assign ctl_o   = ctl_r;
  assign key_o   = tkey_r;
  assign val_o   = tval_r;
  assign delta_o = delta_r;

endmodule

// ===== design/klvs_out.sv =====
// ----------------------------------------------------------------------------
// klvs_out
// Running sum accumulator and result register at the end of the cell chain.
// ----------------------------------------------------------------------------
module klvs_out #(
  parameter int VW = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  klvs_pkg::klvs_ctl_t        ctl_i,
  input  logic [VW:0]                delta_i,
  output logic                       adv,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [klvs_pkg::SUM_W-1:0] out_running_sum,
  output logic                       out_key_was_new,
  output logic                       out_table_full
);

  logic                       valid_r;
  logic [klvs_pkg::SUM_W-1:0] sum_r;
  logic [klvs_pkg::SUM_W-1:0] sum_nxt;
  logic                       new_r;
  logic                       full_r;

  assign adv     = !valid_r || out_ready;
  assign sum_nxt = sum_r + {{(klvs_pkg::SUM_W-VW-1){delta_i[VW]}}, delta_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sum_r   <= '0;
    end else if (adv) begin
      valid_r <= ctl_i.valid;
      if (ctl_i.valid) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_i.valid) begin
      new_r  <= !ctl_i.found;
      full_r <= !ctl_i.found && !ctl_i.placed;
    end
  end

  assign out_valid       = valid_r;
  assign out_running_sum = sum_r;
  assign out_key_was_new = new_r;
  assign out_table_full  = full_r;

endmodule

// ===== design/keyed_latest_value_sum_core.sv =====
// ----------------------------------------------------------------------------
// keyed_latest_value_sum_core
// Keyed table of latest values with a running sum, built as a chain of cells.
// ----------------------------------------------------------------------------
//  channel  direction  payload                                   handshake
//  in       input      in_key, in_new_value                      in_valid/in_ready
//  out      output     out_running_sum, out_key_was_new,         out_valid/out_ready
//                      out_table_full
//
// Each request walks the chain one cell per cycle while it advances, so one
// request can enter every cycle unless a stalled result holds the chain.
// A request passes TABLE_ENTRIES cell registers, then the result register.
// Reset clears every entry's valid bit, the in-flight requests and the sum.
// A stalled result freezes the whole chain, and in_ready drops with it.
// ----------------------------------------------------------------------------
module keyed_latest_value_sum_core #(
  parameter int TABLE_ENTRIES = 256,
  parameter int VALUE_BITS    = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [klvs_pkg::KEY_W-1:0]    in_key,
  input  logic [klvs_pkg::IN_VAL_W-1:0] in_new_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [klvs_pkg::SUM_W-1:0]    out_running_sum,
  output logic                          out_key_was_new,
  output logic                          out_table_full
);

  localparam int VW = (VALUE_BITS < klvs_pkg::MAX_VW) ? VALUE_BITS : klvs_pkg::MAX_VW;

  logic                       adv;
  klvs_pkg::klvs_ctl_t        ctl_w   [TABLE_ENTRIES+1];
  logic [klvs_pkg::KEY_W-1:0] key_w   [TABLE_ENTRIES+1];
  logic [VW-1:0]              val_w   [TABLE_ENTRIES+1];
  logic [VW:0]                delta_w [TABLE_ENTRIES+1];

  assign in_ready          = adv;
  assign ctl_w[0].valid    = in_valid;
  assign ctl_w[0].found    = 1'b0;
  assign ctl_w[0].placed   = 1'b0;
  assign key_w[0]          = in_key;
  assign val_w[0]          = in_new_value[VW-1:0];
  assign delta_w[0]        = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    klvs_cell #(
      .VW(VW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_i  (ctl_w[g]),
      .key_i  (key_w[g]),
      .val_i  (val_w[g]),
      .delta_i(delta_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .key_o  (key_w[g+1]),
      .val_o  (val_w[g+1]),
      .delta_o(delta_w[g+1])
    );
  end

  klvs_out #(
    .VW(VW)
  ) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl_i          (ctl_w[TABLE_ENTRIES]),
    .delta_i        (delta_w[TABLE_ENTRIES]),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_running_sum(out_running_sum),
    .out_key_was_new(out_key_was_new),
    .out_table_full (out_table_full)
  );

endmodule

// ===== design/klvs_checker.sv =====
// ----------------------------------------------------------------------------
// klvs_checker
// Port-level checks on the result channel and the stall path.
// ----------------------------------------------------------------------------
module klvs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [klvs_pkg::SUM_W-1:0] out_running_sum,
  input logic                       out_key_was_new,
  input logic                       out_table_full
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_running_sum)
      && $stable(out_key_was_new) && $stable(out_table_full))
    else $error("result changed while stalled");

  a_full_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_key_was_new)
    else $error("dropped request not flagged as a new key");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while the chain is stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind keyed_latest_value_sum_core klvs_checker u_klvs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_running_sum(out_running_sum),
  .out_key_was_new(out_key_was_new),
  .out_table_full (out_table_full)
);
